/* hdl/srfp_pkg.sv */
// Package for the sensor record field parser: item types, opcodes and constants.
`default_nettype none
package srfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       year;
    logic [7:0]        month;
    logic [7:0]        day;
    logic [7:0]        hour;
    logic [7:0]        minute;
    logic signed [7:0] temperature;
  } out_item_t;

  localparam logic [1:0] ST_VALID  = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic [2:0] OP_DIGIT   = 3'd0;
  localparam logic [2:0] OP_SEMI    = 3'd1;
  localparam logic [2:0] OP_SPACE   = 3'd2;
  localparam logic [2:0] OP_MINUS   = 3'd3;
  localparam logic [2:0] OP_NEWLINE = 3'd4;
  localparam logic [2:0] OP_EOI     = 3'd5;
  localparam logic [2:0] OP_OTHER   = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] digit;
  } q_item_t;

  typedef struct packed {
    logic [15:0] year_min;
    logic [15:0] year_max;
    logic [6:0]  temp_limit;
  } cfg_t;

  localparam logic [1:0] REG_YEAR_MIN   = 2'd0;
  localparam logic [1:0] REG_YEAR_MAX   = 2'd1;
  localparam logic [1:0] REG_TEMP_LIMIT = 2'd2;

  localparam logic [15:0] YEAR_MIN_RST   = 16'd1000;
  localparam logic [15:0] YEAR_MAX_RST   = 16'd2024;
  localparam logic [6:0]  TEMP_LIMIT_RST = 7'd99;

  localparam logic [2:0] FIELD_TEMP = 3'd5;
  localparam logic [2:0] FIELD_LAST = 3'd6;

  localparam logic [7:0] MONTH_MAX  = 8'd12;
  localparam logic [7:0] DAY_MAX    = 8'd31;
  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINUTE_MAX = 8'd59;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int QUEUE_DEPTH_DEF = 4;

endpackage
`default_nettype wire

/* hdl/sensor_record_field_parser_unit.sv */
// Top level of the sensor record field parser: config registers and front/queue/back.
// An item that causes a result is written into the queue, popped by the back end, then registered into out_valid.
// Throughput: one item per cycle; the back end retires one queued item per cycle whenever
// its result register is empty or being taken, and in_stall rises only when the queue is full.
// Reset (rst_n low, synchronous) empties the queue, clears line state and out_valid,
// and restores year_min 1000, year_max 2024, temp_limit 99.
`default_nettype none
module sensor_record_field_parser_unit import srfp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output out_item_t      out_data,
  input  wire            psel,
  input  wire            penable,
  input  wire            pwrite,
  input  wire [3:0]      paddr,
  input  wire [31:0]     pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  cfg_t    cfg_r;
  q_item_t front_item, q_item;
  logic    q_full, q_valid, q_pop;
  logic    cfg_we;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.year_min   <= YEAR_MIN_RST;
      cfg_r.year_max   <= YEAR_MAX_RST;
      cfg_r.temp_limit <= TEMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_YEAR_MIN:   cfg_r.year_min   <= pwdata[15:0];
        REG_YEAR_MAX:   cfg_r.year_max   <= pwdata[15:0];
        REG_TEMP_LIMIT: cfg_r.temp_limit <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_YEAR_MIN:   prdata = {16'h0000, cfg_r.year_min};
      REG_YEAR_MAX:   prdata = {16'h0000, cfg_r.year_max};
      REG_TEMP_LIMIT: prdata = {25'h0, cfg_r.temp_limit};
      default:        prdata = '0;
    endcase
  end

  srfp_front u_front (
    .in_item (in_data),
    .q_item  (front_item)
  );

  srfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_valid),
    .wr_item  (front_item),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  srfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hdl/srfp_front.sv */
// Front end: classifies each input byte into a parser opcode.
`default_nettype none
module srfp_front import srfp_pkg::*; (
  input  wire in_item_t in_item,
  output q_item_t       q_item
);

  always_comb begin
    q_item.digit = in_item.data_byte[3:0];
    if (in_item.end_of_input) begin
      q_item.op = OP_EOI;
    end else if (in_item.data_byte >= CH_ZERO && in_item.data_byte <= CH_NINE) begin
      q_item.op = OP_DIGIT;
    end else begin
      case (in_item.data_byte)
        CH_NEWLINE: q_item.op = OP_NEWLINE;
        CH_SEMI:    q_item.op = OP_SEMI;
        CH_SPACE:   q_item.op = OP_SPACE;
        CH_MINUS:   q_item.op = OP_MINUS;
        default:    q_item.op = OP_OTHER;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/srfp_queue.sv */
// Small FIFO of classified items between front and back.
`default_nettype none
module srfp_queue import srfp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          wr_en,
  input  wire q_item_t wr_item,
  output logic         full,
  input  wire          rd_en,
  output logic         rd_valid,
  output q_item_t      rd_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

/* hdl/srfp_back.sv */
// Back end: field accumulators, line state, range check and result register.
`default_nettype none
module srfp_back import srfp_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  input  wire cfg_t     cfg,
  input  wire           q_valid,
  input  wire q_item_t  q_item,
  output logic          q_pop,
  output logic          out_valid,
  input  wire           out_stall,
  output out_item_t     out_data
);

  logic [2:0]  field_r, field_nxt;
  logic [15:0] year_r, year_nxt;
  logic [7:0]  month_r, month_nxt, day_r, day_nxt;
  logic [7:0]  hour_r, hour_nxt, minute_r, minute_nxt, temp_r, temp_nxt;
  logic        neg_r, neg_nxt, skip_r, skip_nxt, started_r, started_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        emit;
  logic [1:0]  emit_status;
  logic [1:0]  range_status;
  logic [15:0] year_x10;
  logic [7:0]  d8;
  logic signed [8:0] t9, lim9;
  logic        bad;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign year_x10 = {year_r[12:0], 3'b000} + {year_r[14:0], 1'b0};
  assign d8       = {4'h0, q_item.digit};
  assign t9       = {temp_r[7], temp_r};
  assign lim9     = {2'b00, cfg.temp_limit};

  always_comb begin
    bad = (year_r < cfg.year_min) || (year_r > cfg.year_max) ||
          (month_r == 8'd0) || (month_r > MONTH_MAX) ||
          (day_r == 8'd0) || (day_r > DAY_MAX) ||
          (hour_r > HOUR_MAX) || (minute_r > MINUTE_MAX) ||
          (t9 > lim9) || (t9 < -lim9);
    range_status = bad ? ST_RANGE : ST_VALID;
  end

  always_comb begin
    field_nxt   = field_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    temp_nxt    = temp_r;
    neg_nxt     = neg_r;
    skip_nxt    = skip_r;
    started_nxt = started_r;
    emit        = 1'b0;
    emit_status = range_status;
    if (q_pop) begin
      if (q_item.op == OP_EOI || q_item.op == OP_NEWLINE) begin
        emit = !skip_r && (q_item.op == OP_NEWLINE || started_r);
        field_nxt   = '0;
        year_nxt    = '0;
        month_nxt   = '0;
        day_nxt     = '0;
        hour_nxt    = '0;
        minute_nxt  = '0;
        temp_nxt    = '0;
        neg_nxt     = 1'b0;
        skip_nxt    = 1'b0;
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        if (!skip_r) begin
          case (q_item.op)
            OP_DIGIT: begin
              case (field_r)
                3'd0: year_nxt   = year_x10 + {12'h000, q_item.digit};
                3'd1: month_nxt  = {month_r[4:0], 3'b000} + {month_r[6:0], 1'b0} + d8;
                3'd2: day_nxt    = {day_r[4:0], 3'b000} + {day_r[6:0], 1'b0} + d8;
                3'd3: hour_nxt   = {hour_r[4:0], 3'b000} + {hour_r[6:0], 1'b0} + d8;
                3'd4: minute_nxt = {minute_r[4:0], 3'b000} + {minute_r[6:0], 1'b0} + d8;
                FIELD_TEMP: begin
                  if (neg_r) begin
                    temp_nxt = {temp_r[4:0], 3'b000} + {temp_r[6:0], 1'b0} - d8;
                  end else begin
                    temp_nxt = {temp_r[4:0], 3'b000} + {temp_r[6:0], 1'b0} + d8;
                  end
                end
                default: ;
              endcase
            end
            OP_SEMI: begin
              if (field_r < FIELD_LAST) begin
                field_nxt = field_r + 1'b1;
              end
            end
            OP_SPACE: ;
            OP_MINUS: begin
              if (field_r == FIELD_TEMP && temp_r == 8'd0) begin
                neg_nxt = 1'b1;
              end else begin
                emit        = 1'b1;
                emit_status = ST_FORMAT;
                skip_nxt    = 1'b1;
              end
            end
            default: begin
              emit        = 1'b1;
              emit_status = ST_FORMAT;
              skip_nxt    = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = emit_status;
      out_data_nxt.year        = year_r;
      out_data_nxt.month       = month_r;
      out_data_nxt.day         = day_r;
      out_data_nxt.hour        = hour_r;
      out_data_nxt.minute      = minute_r;
      out_data_nxt.temperature = temp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r     <= '0;
      year_r      <= '0;
      month_r     <= '0;
      day_r       <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      temp_r      <= '0;
      neg_r       <= 1'b0;
      skip_r      <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      field_r     <= field_nxt;
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      temp_r      <= temp_nxt;
      neg_r       <= neg_nxt;
      skip_r      <= skip_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* hdl/srfp_checker.sv */
// Port-level checker for the sensor record field parser, bound to the top level.
`default_nettype none
module srfp_checker import srfp_pkg::*; (
  input wire            clk,
  input wire            rst_n,
  input wire            out_valid,
  input wire            out_stall,
  input wire out_item_t out_data,
  input wire            psel,
  input wire            penable,
  input wire            pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_VALID || out_data.status == ST_FORMAT ||
                   out_data.status == ST_RANGE))
    else $error("illegal status code");

  a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_VALID |->
      out_data.month != 8'd0 && out_data.month <= MONTH_MAX &&
      out_data.day != 8'd0 && out_data.day <= DAY_MAX &&
      out_data.hour <= HOUR_MAX && out_data.minute <= MINUTE_MAX)
    else $error("valid record with field out of range");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("config port not ready");

endmodule

bind sensor_record_field_parser_unit srfp_checker u_srfp_checker (.*);
`default_nettype wire
